### design/dfd_pkg.sv
// Shared types and constants for the display frame deframer.
package dfd_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int COUNT_W     = $clog2(FRAME_BYTES);

   localparam logic [COUNT_W-1:0] LAST_INDEX   = COUNT_W'(FRAME_BYTES - 1);
   localparam logic [7:0]         START_BYTE   = 8'hAA;
   localparam logic [7:0]         DEVICE_RESET = 8'h1A;
   localparam logic [3:0]         PHASE_LIMIT  = 4'd3;
   localparam logic [2:0]         PHASE_NONE   = 3'd4;

   localparam int TDATA_W = 104;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_idle;
   } in_item_type;

   typedef struct packed {
      logic        frame_status;
      logic        checksum_ok;
      logic [7:0]  device_id;
      logic [15:0] battery_centivolts;
      logic [15:0] panel_centivolts;
      logic [15:0] panel_deciamps;
      logic [2:0]  charge_phase;
      logic        solar_active;
      logic        overcharge_guard;
      logic        energy_selector;
      logic [39:0] raw_unknown;
   } result_type;

endpackage

### design/dfd_in_reg.sv
// Input register that holds one received word until the assembler takes it.
module dfd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  dfd_pkg::in_item_type req_item,
   input  logic                take,
   output logic                item_valid,
   output dfd_pkg::in_item_type item
);

   logic                 valid_ff, valid_in;
   dfd_pkg::in_item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tvalid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### design/dfd_assembler.sv
// Frame assembly: start hunt, byte store, running checksum, held phase and result decode.
module dfd_assembler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 item_valid,
   input  dfd_pkg::in_item_type item,
   input  logic                 out_free,
   output logic                 take,
   output logic                 result_valid,
   output dfd_pkg::result_type  result
);

   logic [7:0]                  expected_ff;
   logic [dfd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                  xor_ff, xor_in;
   logic [2:0]                  phase_ff, phase_in;
   logic [7:0]                  store_ff [dfd_pkg::FRAME_BYTES];
   logic                        is_last;
   logic                        store_en;
   logic                        match;
   logic [3:0]                  nib;

   // The last word needs room in the output register; other words always move on.
   assign is_last = !item.line_idle && (count_ff == dfd_pkg::LAST_INDEX);
   assign take    = item_valid && (!is_last || out_free);

   assign store_en = take && !item.line_idle
                     && ((count_ff != '0) || (item.rx_byte == dfd_pkg::START_BYTE));
   assign result_valid = take && is_last;

   assign match = (store_ff[1] == expected_ff);
   assign nib   = store_ff[13][3:0];

   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      phase_in = phase_ff;
      if (take && item.line_idle) begin
         count_in = '0;
         xor_in   = '0;
      end else if (store_en) begin
         if (is_last) begin
            count_in = '0;
            xor_in   = '0;
            if (match && (nib <= dfd_pkg::PHASE_LIMIT)) begin
               phase_in = nib[2:0];
            end
         end else begin
            count_in = count_ff + 1'b1;
            xor_in   = xor_ff ^ item.rx_byte;
         end
      end
   end

   always_comb begin
      result              = '0;
      result.device_id    = store_ff[1];
      result.charge_phase = phase_in;
      if (!match) begin
         result.frame_status = 1'b1;
      end else begin
         result.checksum_ok        = (xor_ff == item.rx_byte);
         result.battery_centivolts = {store_ff[3], store_ff[2]};
         result.panel_centivolts   = {store_ff[5], store_ff[4]};
         result.panel_deciamps     = {store_ff[7], store_ff[6]};
         result.solar_active       = store_ff[14][3];
         result.overcharge_guard   = store_ff[14][4];
         result.energy_selector    = store_ff[14][5];
         result.raw_unknown        = {store_ff[12], store_ff[11], store_ff[10],
                                      store_ff[9], store_ff[8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= dfd_pkg::DEVICE_RESET;
         count_ff    <= '0;
         xor_ff      <= '0;
         phase_ff    <= dfd_pkg::PHASE_NONE;
      end else begin
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         xor_ff   <= xor_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         store_ff[count_ff] <= item.rx_byte;
      end
   end

`ifndef NO_ASSERTIONS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= dfd_pkg::PHASE_NONE)
      else $error("held phase out of range");

   a_result_at_end: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (count_ff == dfd_pkg::LAST_INDEX) && !item.line_idle)
      else $error("result outside frame end");

   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      (take && item.line_idle) |=> (count_ff == '0) && (xor_ff == '0))
      else $error("line idle did not drop the frame");

   a_mismatch_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (result_valid && result.frame_status) |=> $stable(phase_ff))
      else $error("device mismatch changed the held phase");
`endif

endmodule

### design/dfd_out_reg.sv
// Output register that holds a finished result until the receiver takes it.
module dfd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dfd_pkg::result_type result,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic                out_free,
   output dfd_pkg::result_type held
);

   logic                valid_ff, valid_in;
   dfd_pkg::result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign held       = data_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded over an unsent word");
`endif

endmodule

### design/display_frame_deframer.sv
// Top level of the display frame deframer.
//
// The req channel carries one received serial byte per word, with the line-idle
// flag in tuser. Bytes are dropped until a start byte 0xAA opens a frame; the
// next fifteen bytes complete it. A line-idle word throws away a partial frame.
// Each complete 16-byte frame gives one word on the rsp channel: the device
// mismatch status in tuser and the decoded fields in tdata.
// The csr port sets the expected device id; write it only while no frame is
// in flight.
// Throughput is one word per cycle unless the last byte of a frame waits for
// the output register. A word is held in the input register; the assembler
// decodes it and loads the output register at the same edge that takes it,
// so a frame's result is valid on rsp in the cycle after the assembler takes
// its last byte. When rsp is stalled, data bytes keep flowing; only the last
// byte of a frame waits in the input register until the output register frees.
// Synchronous reset empties both registers, closes any open frame, sets the
// expected device to 0x1A and the held charge phase to "none seen".
module display_frame_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // rx_byte
   input  logic                        req_tuser,  // line_idle
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // checksum_ok, device_id, battery_centivolts, panel_centivolts,
   // panel_deciamps, charge_phase, solar_active, overcharge_guard,
   // energy_selector, raw_unknown, zero pad
   output logic [dfd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tuser   // frame_status
);

   dfd_pkg::in_item_type req_item, item;
   dfd_pkg::result_type  result, held;
   logic                 item_valid, take, result_valid, out_free;

   assign req_item.rx_byte   = req_tdata;
   assign req_item.line_idle = req_tuser;

   dfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dfd_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .item_valid   (item_valid),
      .item         (item),
      .out_free     (out_free),
      .take         (take),
      .result_valid (result_valid),
      .result       (result)
   );

   dfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_free   (out_free),
      .held       (held)
   );

   assign rsp_tuser = held.frame_status;
   assign rsp_tdata = {1'b0,
                       held.raw_unknown,
                       held.energy_selector,
                       held.overcharge_guard,
                       held.solar_active,
                       held.charge_phase,
                       held.panel_deciamps,
                       held.panel_centivolts,
                       held.battery_centivolts,
                       held.device_id,
                       held.checksum_ok};

endmodule
